// ===== hdl/sha256_pkg.sv =====
// Shared types, constants and bit-mixing functions for the SHA-256 hash block.
package sha256_pkg;

  typedef logic [0:7][31:0] words8_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_PAD,
    ST_EMIT
  } state_t;

  localparam words8_t IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [0:63][31:0] K_TABLE = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_MARK = 8'h80;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] sml_sig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sml_sig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ===== hdl/sha256_hash.sv =====
// SHA-256 over a byte stream: block gather, padding, round sequencer and digest output.
// Throughput: one byte a cycle while a block fills; the 64th byte starts the rounds and then
//   the chaining add on the shared round unit, with input not ready until both are done.
// Last item: padding shifts one byte a cycle up to the block end (twice when the tail is
//   past 55 bytes), each padded block is compressed, then the digest goes out as eight words.
// Reset: synchronous, active low; chaining state to IV, counters clear, no clearing pass.
module sha256_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_has_byte,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha256_pkg::*;

  // Control state
  state_t      state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;       // bytes in the current block
  logic [63:0] bits_r, bits_nxt;       // message length in bits, wraps
  logic [5:0]  rnd_r, rnd_nxt;         // round counter
  logic        pad_r, pad_nxt;         // padding run in progress
  logic        mark_r, mark_nxt;       // 0x80 marker already placed
  logic        len_r, len_nxt;         // this block carries the length field
  logic        fin_r, fin_nxt;         // block under compression is the last one
  logic [2:0]  idx_r, idx_nxt;         // next digest word to load
  words8_t     chain_r, chain_nxt;
  logic        out_valid_r, out_valid_nxt;

  // Payload
  logic [511:0] blk_r, blk_nxt;        // byte shift line, doubles as the schedule window
  words8_t      vars_r, vars_nxt;
  logic [31:0]  out_word_r, out_word_nxt;
  logic [2:0]   out_idx_r, out_idx_nxt;
  logic         out_last_r, out_last_nxt;

  logic         in_fire;
  logic         shift_byte;
  logic [7:0]   byte_in;
  logic [7:0]   pad_byte;
  logic [7:0]   len_byte;
  logic         blk_end;
  logic         emit_load;
  logic [31:0]  w_new;
  words8_t      vars_rnd;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign blk_end   = (fill_r == 6'd63);
  assign emit_load = !out_valid_r || out_ready;

  // Length field goes out most significant byte first at positions 56..63.
  assign len_byte = bits_r[{~fill_r[2:0], 3'b000} +: 8];

  always_comb begin
    priority if (!mark_r) begin
      pad_byte = PAD_MARK;
    end else if (len_r && fill_r[5:3] == 3'b111) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign shift_byte = (in_fire && in_has_byte) || (state_r == ST_PAD);
  assign byte_in    = (state_r == ST_PAD) ? pad_byte : in_data_byte;

  // Rolling schedule: word 0 is used this round, word 16 ahead enters at the tail.
  assign w_new = sml_sig1(blk_r[63:32]) + blk_r[223:192]
               + sml_sig0(blk_r[479:448]) + blk_r[511:480];

  sha256_round u_round (
    .vars_i (vars_r),
    .w_i    (blk_r[511:480]),
    .k_i    (K_TABLE[rnd_r]),
    .vars_o (vars_rnd)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          priority if (in_has_byte && blk_end) begin
            state_nxt = ST_ROUND;
          end else if (in_last_item) begin
            state_nxt = ST_PAD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_ROUND: begin
        if (rnd_r == 6'd63) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        priority if (!pad_r) begin
          state_nxt = ST_IDLE;
        end else if (fin_r) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_PAD;
        end
      end
      ST_PAD: begin
        if (blk_end) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_EMIT: begin
        if (emit_load && idx_r == 3'd7) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and flag updates
  always_comb begin
    fill_nxt      = fill_r;
    bits_nxt      = bits_r;
    rnd_nxt       = rnd_r;
    pad_nxt       = pad_r;
    mark_nxt      = mark_r;
    len_nxt       = len_r;
    fin_nxt       = fin_r;
    idx_nxt       = idx_r;
    chain_nxt     = chain_r;
    blk_nxt       = blk_r;
    vars_nxt      = vars_r;
    out_word_nxt  = out_word_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_ready;

    // Append one byte; a full block loads the working variables for round 0.
    if (shift_byte) begin
      blk_nxt  = {blk_r[503:0], byte_in};
      fill_nxt = fill_r + 6'd1;
      if (blk_end) begin
        vars_nxt = chain_r;
        rnd_nxt  = 6'd0;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && in_has_byte) begin
          bits_nxt = bits_r + 64'd8;
        end
        if (in_fire && in_last_item) begin
          pad_nxt  = 1'b1;
          mark_nxt = 1'b0;
          len_nxt  = 1'b0;
          fin_nxt  = 1'b0;
        end
      end
      ST_ROUND: begin
        vars_nxt = vars_rnd;
        blk_nxt  = {blk_r[479:0], w_new};
        rnd_nxt  = rnd_r + 6'd1;
      end
      ST_FINAL: begin
        for (int i = 0; i < 8; i++) begin
          chain_nxt[i] = chain_r[i] + vars_r[i];
        end
        idx_nxt = 3'd0;
        // A block without the length field is followed by one that has it.
        len_nxt = 1'b1;
      end
      ST_PAD: begin
        if (!mark_r) begin
          mark_nxt = 1'b1;
          len_nxt  = (fill_r[5:3] != 3'b111);
        end
        if (blk_end) begin
          fin_nxt = len_r;
        end
      end
      ST_EMIT: begin
        if (emit_load) begin
          out_word_nxt  = chain_r[idx_r];
          out_idx_nxt   = idx_r;
          out_last_nxt  = (idx_r == 3'd7);
          out_valid_nxt = 1'b1;
          idx_nxt       = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            chain_nxt = IV;
            fill_nxt  = 6'd0;
            bits_nxt  = 64'd0;
            pad_nxt   = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= 6'd0;
      bits_r      <= 64'd0;
      rnd_r       <= 6'd0;
      pad_r       <= 1'b0;
      mark_r      <= 1'b0;
      len_r       <= 1'b0;
      fin_r       <= 1'b0;
      idx_r       <= 3'd0;
      chain_r     <= IV;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      bits_r      <= bits_nxt;
      rnd_r       <= rnd_nxt;
      pad_r       <= pad_nxt;
      mark_r      <= mark_nxt;
      len_r       <= len_nxt;
      fin_r       <= fin_nxt;
      idx_r       <= idx_nxt;
      chain_r     <= chain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r      <= blk_nxt;
    vars_r     <= vars_nxt;
    out_word_r <= out_word_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_index  = out_idx_r;
  assign out_last_word   = out_last_r;

  // A compression always starts on a block boundary at round zero.
  a_round_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && $past(state_r) != ST_ROUND) |-> (fill_r == 6'd0 && rnd_r == 6'd0))
    else $error("compression started off a block boundary");

  // The round counter's last value hands over to the chaining add.
  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && rnd_r == 6'd63) |=> (state_r == ST_FINAL))
    else $error("round sequence did not end in the chaining add");

  // After the final word transfer the output holds nothing, or the next digest's first word.
  a_last_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_word) |=> (!out_valid || out_word_index == 3'd0))
    else $error("output still valid after the final digest word");

  // Leaving digest output restarts the message counters.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && state_nxt == ST_IDLE) |=> (fill_r == 6'd0 && bits_r == 64'd0))
    else $error("counters not cleared after digest");

  // Input is refused while any block work or digest output is under way.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND || state_r == ST_PAD || state_r == ST_EMIT) |-> !in_ready)
    else $error("input ready while busy");

endmodule

// ===== hdl/sha256_round.sv =====
// One SHA-256 compression round: working variables in, updated variables out.
module sha256_round (
  input  sha256_pkg::words8_t vars_i,
  input  logic [31:0]         w_i,
  input  logic [31:0]         k_i,
  output sha256_pkg::words8_t vars_o
);
  import sha256_pkg::*;

  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] t1;
  logic [31:0] t2;

  assign ch  = (vars_i[4] & vars_i[5]) ^ (~vars_i[4] & vars_i[6]);
  assign maj = (vars_i[0] & vars_i[1]) ^ (vars_i[0] & vars_i[2]) ^ (vars_i[1] & vars_i[2]);
  assign t1  = vars_i[7] + big_sig1(vars_i[4]) + ch + k_i + w_i;
  assign t2  = big_sig0(vars_i[0]) + maj;

  assign vars_o = {t1 + t2, vars_i[0], vars_i[1], vars_i[2],
                   vars_i[3] + t1, vars_i[4], vars_i[5], vars_i[6]};

endmodule
